/* design/mvsm_pkg.sv */
// shared types and constants for the multi-voice sample mixer
`default_nettype none
package mvsm_pkg;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [15:0] GAIN_UNITY = 16'd32768;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        address;
    logic [16:0]        end_address;
    logic signed [15:0] sample_word;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [4:0]         active_voices;
  } out_t;

endpackage
`default_nettype wire

/* design/mvsm_ram.sv */
// generic single write port, single read port ram with registered read
`default_nettype none
module mvsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/mvsm_front.sv */
// input stage: accepts words, drops unknown kinds, queues the rest
`default_nettype none
module mvsm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mvsm_pkg::in_t in_data,
  output logic               q_valid,
  output mvsm_pkg::in_t      q_data,
  input  wire logic          q_pop
);
  mvsm_pkg::in_t slot [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;
  logic          push;
  logic          take;

  assign in_ready = (count != 2'd2);
  assign take     = in_valid && in_ready;
  assign push     = take && (in_data.kind != mvsm_pkg::KIND_UNUSED);
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop && q_valid);
    end
  end
endmodule
`default_nettype wire

/* design/mvsm_engine.sv */
// back end: sample loads, voice table and per-frame mixing sequencer
`default_nettype none
module mvsm_engine #(
  parameter int VOICES       = 16,
  parameter int SAMPLE_WORDS = 65536
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          q_valid,
  input  wire mvsm_pkg::in_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mvsm_pkg::out_t     out_data
);
  localparam int AW = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
  localparam int XW = (AW > 18) ? AW : 18;
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDV  = 3'd1;
  localparam logic [2:0] S_WV   = 3'd2;
  localparam logic [2:0] S_WS0  = 3'd3;
  localparam logic [2:0] S_WS1  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_MV   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]         state;
  logic [15:0]        gain;
  logic [CW-1:0]      total;
  logic [CW-1:0]      idx;
  logic [16:0]        pos;
  logic [16:0]        lim;
  logic [15:0]        left;
  logic [15:0]        right;
  logic signed [32:0] prod;

  logic               s_we;
  logic [AW-1:0]      s_waddr;
  logic [AW-1:0]      s_raddr;
  logic [15:0]        s_rdata;
  logic               v_we;
  logic [VW-1:0]      v_waddr;
  logic [33:0]        v_wdata;
  logic [VW-1:0]      v_raddr;
  logic [33:0]        v_rdata;

  logic [XW-1:0]      load_x;
  logic [XW-1:0]      rd0_x;
  logic [XW-1:0]      rd1_x;
  logic [17:0]        pos_adv;
  logic               ended;
  logic [CW-1:0]      last;
  logic               start_ok;
  logic               out_load;

  function automatic logic [15:0] scale(input logic signed [32:0] p);
    logic signed [32:0] a;
    a = p + (p[32] ? 33'sd32767 : 33'sd0);
    return a[30:15];
  endfunction

  assign load_x   = XW'(q_data.address);
  assign rd0_x    = XW'(v_rdata[16:0]);
  assign rd1_x    = XW'({1'b0, pos} + 18'd1);
  assign pos_adv  = {1'b0, pos} + 18'd2;
  assign ended    = pos_adv >= {1'b0, lim};
  assign last     = total - CW'(1);
  assign start_ok = (total < CW'(VOICES)) && ({1'b0, q_data.address} < q_data.end_address);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  assign s_we    = q_pop && (q_data.kind == mvsm_pkg::KIND_LOAD);
  assign s_waddr = load_x[AW-1:0];
  assign s_raddr = (state == S_WV) ? rd0_x[AW-1:0] : rd1_x[AW-1:0];

  always_comb begin
    v_we    = 1'b0;
    v_waddr = idx[VW-1:0];
    v_wdata = {lim, pos_adv[16:0]};
    if (q_pop && (q_data.kind == mvsm_pkg::KIND_START) && start_ok) begin
      v_we    = 1'b1;
      v_waddr = total[VW-1:0];
      v_wdata = {q_data.end_address, 1'b0, q_data.address};
    end else if (state == S_ACC && !ended) begin
      v_we = 1'b1;
    end else if (state == S_MV) begin
      v_we    = 1'b1;
      v_wdata = v_rdata;
    end
  end

  assign v_raddr = (state == S_ACC) ? last[VW-1:0] : idx[VW-1:0];

  mvsm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_samples (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (q_data.sample_word),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  mvsm_ram #(.WIDTH(34), .DEPTH(VOICES)) u_voices (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.left_out      <= left;
      out_data.right_out     <= right;
      out_data.active_voices <= 5'(total);
    end
    if (rst) begin
      state     <= S_IDLE;
      gain      <= mvsm_pkg::GAIN_UNITY;
      total     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        gain <= cfg_data;
      end
      out_valid <= out_load || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_data.kind == mvsm_pkg::KIND_START && start_ok) begin
              total <= total + CW'(1);
            end
            if (q_data.kind == mvsm_pkg::KIND_TICK) begin
              left  <= '0;
              right <= '0;
              idx   <= '0;
              state <= (total == '0) ? S_DONE : S_RDV;
            end
          end
        end
        S_RDV: state <= S_WV;
        S_WV: begin
          pos   <= v_rdata[16:0];
          lim   <= v_rdata[33:17];
          state <= S_WS0;
        end
        S_WS0: begin
          prod  <= $signed(s_rdata) * $signed({1'b0, gain});
          state <= S_WS1;
        end
        S_WS1: begin
          left  <= left + scale(prod);
          prod  <= $signed(s_rdata) * $signed({1'b0, gain});
          state <= S_ACC;
        end
        S_ACC: begin
          right <= right + scale(prod);
          if (ended) begin
            state <= S_MV;
          end else begin
            idx   <= idx + CW'(1);
            state <= (idx + CW'(1) < total) ? S_RDV : S_DONE;
          end
        end
        S_MV: begin
          total <= last;
          state <= (idx < last) ? S_RDV : S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/multi_voice_sample_mixer_core.sv */
// top level of the multi-voice sample mixer
//
//   port group        dir   handshake        word
//   in_*              in    valid / ready    mvsm_pkg::in_t
//   out_*             out   valid / ready    mvsm_pkg::out_t
//   cfg_*             in    write enable     16-bit voice gain
//
// load and start words are handled in the back end's idle state; a tick steps
// each active voice through RDV, WV, WS0, WS1 and ACC (and MV if it ends), set
// by the single read port of the sample ram and the shared multiplier
// a two-word input queue takes words while the back end works or the output
// register waits, until it is full; unknown kinds are dropped on entry
// synchronous reset clears the voice count, gain to unity and all handshakes
`default_nettype none
module multi_voice_sample_mixer_core #(
  parameter int VOICES       = 16,
  parameter int SAMPLE_WORDS = 65536
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mvsm_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mvsm_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [15:0]    cfg_data
);
  logic          q_valid;
  mvsm_pkg::in_t q_data;
  logic          q_pop;

  mvsm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  mvsm_engine #(.VOICES(VOICES), .SAMPLE_WORDS(SAMPLE_WORDS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

/* sim/multi_voice_sample_mixer_core_tb.sv */
// testbench for the multi-voice sample mixer: directed table, then random words
`default_nettype none
module multi_voice_sample_mixer_core_tb;

  localparam int VOICE_SLOTS = 16;
  localparam int LIMIT_CYCLES = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mvsm_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mvsm_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  multi_voice_sample_mixer_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic signed [15:0] mem_words [logic [15:0]];
  logic [16:0] pos_q [VOICE_SLOTS];
  logic [16:0] lim_q [VOICE_SLOTS];
  int unsigned n_voices;
  logic [15:0] gain_q;

  mvsm_pkg::out_t frame_q [$];
  int mismatches = 0;
  int unsigned cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic [15:0] scaled(logic signed [15:0] s);
    logic signed [33:0] p;
    logic [33:0] mag;
    logic [33:0] q;
    p = $signed(s) * $signed({1'b0, gain_q});
    mag = (p < 0) ? -p : p;
    q = mag >> 15;
    if (p < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic logic signed [15:0] word_at(logic [16:0] a);
    if (mem_words.exists(a[15:0])) return mem_words[a[15:0]];
    return 16'sd0;
  endfunction

  function automatic void mix_apply(mvsm_pkg::in_t w);
    logic [15:0] l, r;
    logic [17:0] np;
    int unsigned i;
    mvsm_pkg::out_t f;
    case (w.kind)
      mvsm_pkg::KIND_LOAD: mem_words[w.address] = w.sample_word;
      mvsm_pkg::KIND_START: begin
        if (n_voices < VOICE_SLOTS && {1'b0, w.address} < w.end_address) begin
          pos_q[n_voices] = {1'b0, w.address};
          lim_q[n_voices] = w.end_address;
          n_voices++;
        end
      end
      mvsm_pkg::KIND_TICK: begin
        l = 0; r = 0; i = 0;
        while (i < n_voices) begin
          l += scaled(word_at(pos_q[i]));
          r += scaled(word_at(pos_q[i] + 17'd1));
          np = {1'b0, pos_q[i]} + 18'd2;
          pos_q[i] = np[16:0];
          if (np >= {1'b0, lim_q[i]}) begin
            pos_q[i] = pos_q[n_voices - 1];
            lim_q[i] = lim_q[n_voices - 1];
            n_voices--;
          end else begin
            i++;
          end
        end
        f.left_out = l;
        f.right_out = r;
        f.active_voices = n_voices[4:0];
        frame_q.push_back(f);
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(mvsm_pkg::in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mix_apply(w);
  endtask

  task automatic set_gain(logic [15:0] g);
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_q = g;
  endtask

  function automatic mvsm_pkg::in_t mk(logic [1:0] k, logic [15:0] a, logic [16:0] e,
                                       logic [15:0] s);
    mvsm_pkg::in_t w;
    w.kind = k; w.address = a; w.end_address = e; w.sample_word = s;
    return w;
  endfunction

  // receiver and checker
  always @(posedge clk) begin
    mvsm_pkg::out_t exp_f;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected frame %p", out_data);
        end else begin
          exp_f = frame_q.pop_front();
          if (out_data !== exp_f) begin
            mismatches++;
            if (mismatches <= 10) $display("frame mismatch exp %p got %p", exp_f, out_data);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // directed rows; exp_on marks rows with a typed-in frame
  typedef struct {
    mvsm_pkg::in_t w;
    bit exp_on;
    mvsm_pkg::out_t f;
  } row_t;

  row_t rows [$];

  task automatic add_row(mvsm_pkg::in_t w, bit e, logic [15:0] l, logic [15:0] r,
                         logic [4:0] n);
    row_t x;
    x.w = w; x.exp_on = e;
    x.f.left_out = l; x.f.right_out = r; x.f.active_voices = n;
    rows.push_back(x);
  endtask

  task automatic random_phase(int count, int s_pct, int r_pct);
    int base;
    int len;
    int t;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int k = 0; k < count; k++) begin
      t = $urandom_range(99);
      if (t < 12) begin
        base = $urandom_range(0, 63) * 2;
        len = $urandom_range(1, 12);
        if ($urandom_range(9) == 0) base = 16'hFFF0;
        send_word(mk(mvsm_pkg::KIND_START, base[15:0], 17'(base + len), 16'($urandom)));
      end else if (t < 20) begin
        send_word(mk(mvsm_pkg::KIND_START, 16'($urandom_range(0, 139)),
                     17'($urandom_range(0, 140)), 16'($urandom)));
      end else if (t < 22) begin
        send_word(mk(mvsm_pkg::KIND_UNUSED, 16'($urandom), 17'($urandom), 16'($urandom)));
      end else if (t < 35) begin
        send_word(mk(mvsm_pkg::KIND_LOAD, 16'($urandom_range(0, 141)), 17'($urandom),
                     16'($urandom)));
      end else begin
        send_word(mk(mvsm_pkg::KIND_TICK, 16'($urandom), 17'($urandom), 16'($urandom)));
      end
    end
  endtask

  initial begin
    gain_q = mvsm_pkg::GAIN_UNITY;
    n_voices = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all addresses a voice can read, including the top of memory for wrap
    for (int a = 0; a < 142; a++) begin
      send_word(mk(mvsm_pkg::KIND_LOAD, 16'(a), 17'($urandom), 16'($urandom)));
    end
    for (int a = 16'hFFF0; a <= 16'hFFFF; a++) begin
      send_word(mk(mvsm_pkg::KIND_LOAD, 16'(a), 17'($urandom), 16'($urandom)));
    end

    add_row(mk(mvsm_pkg::KIND_TICK, 16'hFFFF, 17'h1FFFF, 16'hFFFF), 1, 16'd0, 16'd0, 5'd0);
    add_row(mk(mvsm_pkg::KIND_LOAD, 16'd200, 17'd0, 16'sh7FFF), 0, 0, 0, 0);
    add_row(mk(mvsm_pkg::KIND_LOAD, 16'd201, 17'd0, 16'sh8000), 0, 0, 0, 0);
    add_row(mk(mvsm_pkg::KIND_START, 16'd200, 17'd202, 16'hFFFF), 0, 0, 0, 0);
    add_row(mk(mvsm_pkg::KIND_TICK, 16'd0, 17'd0, 16'd0), 1, 16'h7FFF, 16'h8000, 5'd0);
    add_row(mk(mvsm_pkg::KIND_START, 16'd10, 17'd10, 16'd0), 0, 0, 0, 0);
    add_row(mk(mvsm_pkg::KIND_START, 16'd10, 17'd3, 16'd0), 0, 0, 0, 0);
    add_row(mk(mvsm_pkg::KIND_UNUSED, 16'd200, 17'd202, 16'd5), 0, 0, 0, 0);
    add_row(mk(mvsm_pkg::KIND_TICK, 16'd0, 17'd0, 16'd0), 1, 16'd0, 16'd0, 5'd0);
    add_row(mk(mvsm_pkg::KIND_START, 16'd3, 17'd8, 16'd0), 0, 0, 0, 0);
    add_row(mk(mvsm_pkg::KIND_START, 16'hFFFE, 17'h10002, 16'd0), 0, 0, 0, 0);
    add_row(mk(mvsm_pkg::KIND_TICK, 16'd0, 17'd0, 16'd0), 0, 0, 0, 0);
    add_row(mk(mvsm_pkg::KIND_TICK, 16'd0, 17'd0, 16'd0), 0, 0, 0, 0);
    add_row(mk(mvsm_pkg::KIND_TICK, 16'd0, 17'd0, 16'd0), 0, 0, 0, 0);
    for (int v = 0; v < 18; v++)
      add_row(mk(mvsm_pkg::KIND_START, 16'(v * 4), 17'(v * 4 + 40), 16'd0), 0, 0, 0, 0);
    add_row(mk(mvsm_pkg::KIND_TICK, 16'd0, 17'd0, 16'd0), 0, 0, 0, 0);

    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].exp_on && frame_q.size() != 0 && frame_q[$] !== rows[i].f) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d exp %p pred %p", i, rows[i].f, frame_q[$]);
      end
    end
    for (int k = 0; k < 25; k++) send_word(mk(mvsm_pkg::KIND_TICK, 16'd0, 17'd0, 16'd0));

    random_phase(350, 0, 0);
    set_gain(16'd0);
    random_phase(300, 67, 0);
    set_gain(16'hFFFF);
    random_phase(300, 0, 67);
    set_gain(16'd12345);
    random_phase(300, 13, 13);
    set_gain(16'd1);
    random_phase(200, 0, 0);
    set_gain(mvsm_pkg::GAIN_UNITY);
    random_phase(50, 40, 40);

    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
